// ----- design/ptlc_pkg.sv -----
package ptlc_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned BeepW  = 6;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [TickW-1:0] GreenReset    = TickW'(80);
  localparam logic [TickW-1:0] YellowReset   = TickW'(20);
  localparam logic [TickW-1:0] RedReset      = TickW'(100);
  localparam logic [TickW-1:0] ClearReset    = TickW'(50);
  localparam logic [BeepW-1:0] BeepCntReset  = BeepW'(15);
  localparam logic [BeepW-1:0] BeepOnReset   = BeepW'(5);
  localparam logic [BeepW-1:0] BeepOffReset  = BeepW'(5);

  // Controller phase, one-hot.
  typedef enum logic [4:0] {
    PH_GREEN  = 5'b00001,
    PH_YELLOW = 5'b00010,
    PH_RED    = 5'b00100,
    PH_CLEAR  = 5'b01000,
    PH_WALK   = 5'b10000
  } phase_e;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_GREEN    = 3'd0,
    REG_YELLOW   = 3'd1,
    REG_RED      = 3'd2,
    REG_CLEAR    = 3'd3,
    REG_BEEP_CNT = 3'd4,
    REG_BEEP_ON  = 3'd5,
    REG_BEEP_OFF = 3'd6
  } reg_idx_e;

  // Lamp and buzzer levels for one tick.
  typedef struct packed {
    logic car_red;
    logic car_yellow;
    logic car_green;
    logic walk_red;
    logic walk_green;
    logic buzzer_on;
  } lamps_t;

endpackage

// ----- design/pedestrian_traffic_light_controller_core.sv -----
// Pedestrian traffic light controller. Each input beat is one 100 ms tick that
// carries the sampled pedestrian button; each tick yields exactly one output beat
// with the vehicle lamps, pedestrian lamps and buzzer level of the phase in force
// at the start of that tick. The vehicle cycle runs green, yellow and red for the
// programmed tick counts. A button seen during any vehicle tick starts the
// pedestrian sequence on the next tick: a yellow clearance, then a walk phase with
// vehicle red, pedestrian green and a beeping buzzer, then back to vehicle green.
// The block takes one tick per clock cycle while in_stall_o is low: the phase
// update is one counter compare and increment between the phase registers and
// the result register; a result is written there, or to the skid register, as
// its tick is accepted. A two-entry output buffer (result and skid registers)
// lets a new tick be accepted while a finished result waits; in_stall_o rises
// only when both entries are full. Timing registers sit on an APB-style port at
// byte address 4*index and should be written only while no tick is in flight.
module pedestrian_traffic_light_controller_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Tick input channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        button_pressed_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        car_red_o,
  output logic                        car_yellow_o,
  output logic                        car_green_o,
  output logic                        walk_red_o,
  output logic                        walk_green_o,
  output logic                        buzzer_on_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptlc_pkg::AddrW-1:0]  paddr,
  input  logic [ptlc_pkg::DataW-1:0]  pwdata,
  output logic [ptlc_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  // Configuration registers.
  logic [ptlc_pkg::TickW-1:0] green_q, yellow_q, red_q, clear_q;
  logic [ptlc_pkg::BeepW-1:0] beep_cnt_q, beep_on_q, beep_off_q;

  ptlc_pkg::reg_idx_e reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = ptlc_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_q    <= ptlc_pkg::GreenReset;
      yellow_q   <= ptlc_pkg::YellowReset;
      red_q      <= ptlc_pkg::RedReset;
      clear_q    <= ptlc_pkg::ClearReset;
      beep_cnt_q <= ptlc_pkg::BeepCntReset;
      beep_on_q  <= ptlc_pkg::BeepOnReset;
      beep_off_q <= ptlc_pkg::BeepOffReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ptlc_pkg::REG_GREEN:    green_q    <= pwdata[ptlc_pkg::TickW-1:0];
        ptlc_pkg::REG_YELLOW:   yellow_q   <= pwdata[ptlc_pkg::TickW-1:0];
        ptlc_pkg::REG_RED:      red_q      <= pwdata[ptlc_pkg::TickW-1:0];
        ptlc_pkg::REG_CLEAR:    clear_q    <= pwdata[ptlc_pkg::TickW-1:0];
        ptlc_pkg::REG_BEEP_CNT: beep_cnt_q <= pwdata[ptlc_pkg::BeepW-1:0];
        ptlc_pkg::REG_BEEP_ON:  beep_on_q  <= pwdata[ptlc_pkg::BeepW-1:0];
        ptlc_pkg::REG_BEEP_OFF: beep_off_q <= pwdata[ptlc_pkg::BeepW-1:0];
        default: ;
      endcase
    end
  end

  // Read data: registers zero-extended; the unused slot reads as zero.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      ptlc_pkg::REG_GREEN:    prdata = ptlc_pkg::DataW'(green_q);
      ptlc_pkg::REG_YELLOW:   prdata = ptlc_pkg::DataW'(yellow_q);
      ptlc_pkg::REG_RED:      prdata = ptlc_pkg::DataW'(red_q);
      ptlc_pkg::REG_CLEAR:    prdata = ptlc_pkg::DataW'(clear_q);
      ptlc_pkg::REG_BEEP_CNT: prdata = ptlc_pkg::DataW'(beep_cnt_q);
      ptlc_pkg::REG_BEEP_ON:  prdata = ptlc_pkg::DataW'(beep_on_q);
      ptlc_pkg::REG_BEEP_OFF: prdata = ptlc_pkg::DataW'(beep_off_q);
      default:                prdata = '0;
    endcase
  end

  // Controller state.
  ptlc_pkg::phase_e           phase_q, phase_d, eff_phase;
  logic [ptlc_pkg::TickW-1:0] tick_q, tick_d;
  logic [ptlc_pkg::BeepW-1:0] beeps_q, beeps_d;

  logic                       in_acc;
  ptlc_pkg::lamps_t           lamps;

  // Span length for the current phase, and whether this tick completes it.
  // One extra bit keeps tick + 1 from wrapping; a length of zero acts like one.
  logic [ptlc_pkg::TickW:0]   span_len;
  logic [ptlc_pkg::TickW:0]   tick_inc;
  logic                       span_done;
  logic [ptlc_pkg::BeepW:0]   beep_period;
  logic                       beeps_last;

  // Any code outside the one-hot set behaves as vehicle green.
  always_comb begin
    unique case (phase_q)
      ptlc_pkg::PH_GREEN,
      ptlc_pkg::PH_YELLOW,
      ptlc_pkg::PH_RED,
      ptlc_pkg::PH_CLEAR,
      ptlc_pkg::PH_WALK:  eff_phase = phase_q;
      default:            eff_phase = ptlc_pkg::PH_GREEN;
    endcase
  end

  assign beep_period = {1'b0, beep_on_q} + {1'b0, beep_off_q};
  assign tick_inc    = {1'b0, tick_q} + (ptlc_pkg::TickW+1)'(1);
  assign beeps_last  = ({1'b0, beeps_q} + (ptlc_pkg::BeepW+1)'(1)) >= {1'b0, beep_cnt_q};

  always_comb begin
    unique case (eff_phase)
      ptlc_pkg::PH_YELLOW: span_len = {1'b0, yellow_q};
      ptlc_pkg::PH_RED:    span_len = {1'b0, red_q};
      ptlc_pkg::PH_CLEAR:  span_len = {1'b0, clear_q};
      ptlc_pkg::PH_WALK:   span_len = (ptlc_pkg::TickW+1)'(beep_period);
      default:             span_len = {1'b0, green_q};
    endcase
  end

  assign span_done = tick_inc >= span_len;

  // Lamps come from the phase in force at the start of the tick. Pedestrian red
  // stays lit in every phase but walk, including the clearance.
  always_comb begin
    lamps.car_red    = (eff_phase == ptlc_pkg::PH_RED) || (eff_phase == ptlc_pkg::PH_WALK);
    lamps.car_yellow = (eff_phase == ptlc_pkg::PH_YELLOW) ||
                       (eff_phase == ptlc_pkg::PH_CLEAR);
    lamps.car_green  = (eff_phase == ptlc_pkg::PH_GREEN);
    lamps.walk_red   = (eff_phase != ptlc_pkg::PH_WALK);
    lamps.walk_green = (eff_phase == ptlc_pkg::PH_WALK);
    lamps.buzzer_on  = (eff_phase == ptlc_pkg::PH_WALK) &&
                       (tick_q < ptlc_pkg::TickW'(beep_on_q));
  end

  // Phase update. The button wins over a phase advance in the vehicle phases and
  // is ignored during clearance and walk.
  always_comb begin
    phase_d = eff_phase;
    tick_d  = tick_inc[ptlc_pkg::TickW-1:0];
    beeps_d = beeps_q;
    unique case (eff_phase)
      ptlc_pkg::PH_CLEAR: begin
        if (span_done) begin
          phase_d = ptlc_pkg::PH_WALK;
          tick_d  = '0;
          beeps_d = '0;
        end
      end
      ptlc_pkg::PH_WALK: begin
        if (span_done) begin
          tick_d = '0;
          if (beeps_last) begin
            phase_d = ptlc_pkg::PH_GREEN;
            beeps_d = '0;
          end else begin
            beeps_d = beeps_q + ptlc_pkg::BeepW'(1);
          end
        end
      end
      default: begin
        if (button_pressed_i) begin
          phase_d = ptlc_pkg::PH_CLEAR;
          tick_d  = '0;
          beeps_d = '0;
        end else if (span_done) begin
          tick_d  = '0;
          beeps_d = '0;
          unique case (eff_phase)
            ptlc_pkg::PH_YELLOW: phase_d = ptlc_pkg::PH_RED;
            ptlc_pkg::PH_RED:    phase_d = ptlc_pkg::PH_GREEN;
            default:             phase_d = ptlc_pkg::PH_YELLOW;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ptlc_pkg::PH_GREEN;
      tick_q  <= '0;
      beeps_q <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      beeps_q <= beeps_d;
    end
  end

  // Output buffer: a result register and a skid register behind it. Results
  // always leave from the result register, so order is kept.
  logic             out_valid_q, skid_valid_q;
  ptlc_pkg::lamps_t out_q, skid_q;
  logic             out_free;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= lamps;
      end
    end else if (in_acc) begin
      skid_q <= lamps;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign car_red_o    = out_q.car_red;
  assign car_yellow_o = out_q.car_yellow;
  assign car_green_o  = out_q.car_green;
  assign walk_red_o   = out_q.walk_red;
  assign walk_green_o = out_q.walk_green;
  assign buzzer_on_o  = out_q.buzzer_on;

endmodule

// ----- design/ptlc_checker.sv -----
module ptlc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic car_red_o,
  input logic car_yellow_o,
  input logic car_green_o,
  input logic walk_red_o,
  input logic walk_green_o,
  input logic buzzer_on_o
);

  // Exactly one vehicle lamp is lit in every result beat.
  a_one_car_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({car_red_o, car_yellow_o, car_green_o}))
    else $error("vehicle lamps not one-hot");

  // Pedestrian red and green are never lit together nor both dark.
  a_walk_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (walk_red_o != walk_green_o))
    else $error("pedestrian lamps inconsistent");

  // Pedestrians only walk against vehicle red.
  a_walk_car_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && walk_green_o) |-> car_red_o)
    else $error("walk shown without vehicle red");

  // The buzzer sounds only during walk.
  a_buzzer_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && buzzer_on_o) |-> walk_green_o)
    else $error("buzzer outside walk");

  // The input side stalls only while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind pedestrian_traffic_light_controller_core ptlc_checker u_ptlc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .car_red_o    (car_red_o),
  .car_yellow_o (car_yellow_o),
  .car_green_o  (car_green_o),
  .walk_red_o   (walk_red_o),
  .walk_green_o (walk_green_o),
  .buzzer_on_o  (buzzer_on_o)
);
